// File: design/lppd_pkg.sv
// Package for the length-prefixed packet deframer with acknowledge.
// Holds result kind codes, frame constants and the command type passed from the parser
// to the result sequencer. It depends on nothing.
`default_nettype none

package lppd_pkg;

	// Result kind codes as they appear on the kind port.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_STATUS  = 2'd1;
	localparam logic [1:0] KIND_ACK     = 2'd2;

	// Frame and acknowledge byte values.
	localparam logic [7:0] TERM_BYTE = 8'hA5;
	localparam logic [7:0] ACK_HEAD  = 8'h01;
	localparam logic [7:0] ACK_MARK  = 8'hAA;

	// Default depth of the command queue between parser and sequencer.
	localparam int CMD_DEPTH = 4;

	// What the sequencer has to do for one queued command.
	typedef enum logic [1:0] {
		CMD_PAYLOAD,
		CMD_GOOD,
		CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic [7:0] opcode;
		logic [7:0] length;
	} cmd_t;

endpackage

`default_nettype wire

// File: design/lppd_front.sv
// Frame parser: tracks the frame layout byte by byte and emits one command per byte that
// causes results. Depends on lppd_pkg.
`default_nettype none

module lppd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              take,
	input  wire  [7:0]       rx_byte,
	output logic             cmd_valid,
	output lppd_pkg::cmd_t   cmd
);
	import lppd_pkg::*;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_OPC,
		PH_DATA,
		PH_TERM
	} phase_t;

	phase_t     phase_q;
	logic [7:0] length_q;
	logic [7:0] opcode_q;
	logic [7:0] count_q;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	// Command for the byte on the input this cycle; only used when take is high.
	always_comb begin
		cmd_valid      = 1'b0;
		cmd.kind       = CMD_PAYLOAD;
		cmd.byte_value = rx_byte;
		cmd.byte_index = count_q;
		cmd.opcode     = opcode_q;
		cmd.length     = length_q;
		unique case (phase_q)
			PH_DATA: begin
				cmd_valid = take;
			end
			PH_TERM: begin
				cmd_valid = take;
				cmd.kind  = (rx_byte == TERM_BYTE) ? CMD_GOOD : CMD_BAD;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			length_q <= '0;
			opcode_q <= '0;
			count_q  <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_LEN: begin
					length_q <= rx_byte;
					count_q  <= '0;
					phase_q  <= PH_OPC;
				end
				PH_OPC: begin
					opcode_q <= rx_byte;
					count_q  <= '0;
					phase_q  <= (length_q == 8'd0) ? PH_TERM : PH_DATA;
				end
				PH_DATA: begin
					count_q <= count_inc;
					if (count_inc >= length_q) begin
						phase_q <= PH_TERM;
					end
				end
				default: begin
					count_q <= '0;
					phase_q <= PH_LEN;
				end
			endcase
		end
	end

	// Payload is only ever collected for a frame with a nonzero length.
	a_data_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> length_q != 8'd0)
		else $error("payload phase entered with zero length");

endmodule

`default_nettype wire

// File: design/lppd_cmd_fifo.sv
// Small command queue between the frame parser and the result sequencer.
// Register storage with read and write pointers. Depends on lppd_pkg.
`default_nettype none

module lppd_cmd_fifo #(
	parameter int Depth = lppd_pkg::CMD_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	input  lppd_pkg::cmd_t   wr_cmd,
	input  wire              rd_en,
	output lppd_pkg::cmd_t   rd_cmd,
	output logic             full,
	output logic             empty
);
	import lppd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full   = (count_q == CntW'(Depth));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/lppd_back.sv
// Result sequencer: expands each queued command into one or five results and holds the
// oldest result in an output register. Depends on lppd_pkg.
`default_nettype none

module lppd_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_avail,
	input  lppd_pkg::cmd_t   cmd,
	output logic             cmd_done,
	input  wire              pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [7:0]       byte_value,
	output logic [7:0]       byte_index,
	output logic [7:0]       frame_opcode,
	output logic [7:0]       frame_length,
	output logic             frame_good,
	output logic             last
);
	import lppd_pkg::*;

	// Positions within the five results of a good frame.
	localparam logic [2:0] STEP_STATUS = 3'd0;
	localparam logic [2:0] STEP_HEAD   = 3'd1;
	localparam logic [2:0] STEP_MARK   = 3'd2;
	localparam logic [2:0] STEP_OPCODE = 3'd3;
	localparam logic [2:0] STEP_TERM   = 3'd4;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic       load;
	logic       final_step;
	logic [1:0] nx_kind;
	logic [7:0] nx_value;
	logic [7:0] nx_index;
	logic       nx_good;

	assign load     = cmd_avail && (!out_valid_q || pop);
	assign cmd_done = load && final_step;
	assign empty    = !out_valid_q;

	always_comb begin
		final_step = 1'b1;
		nx_kind    = KIND_PAYLOAD;
		nx_value   = 8'd0;
		nx_index   = 8'd0;
		nx_good    = 1'b0;
		unique case (cmd.kind)
			CMD_PAYLOAD: begin
				nx_value = cmd.byte_value;
				nx_index = cmd.byte_index;
			end
			CMD_BAD: begin
				nx_kind = KIND_STATUS;
			end
			CMD_GOOD: begin
				nx_good    = 1'b1;
				final_step = (step_q == STEP_TERM);
				nx_kind    = KIND_ACK;
				case (step_q)
					STEP_STATUS: nx_kind  = KIND_STATUS;
					STEP_HEAD:   nx_value = ACK_HEAD;
					STEP_MARK:   nx_value = ACK_MARK;
					STEP_OPCODE: nx_value = cmd.opcode;
					default:     nx_value = TERM_BYTE;
				endcase
			end
			default: begin
				nx_kind = KIND_STATUS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_STATUS;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= final_step ? STEP_STATUS : step_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind         <= nx_kind;
			byte_value   <= nx_value;
			byte_index   <= nx_index;
			frame_opcode <= cmd.opcode;
			frame_length <= cmd.length;
			frame_good   <= nx_good;
			last         <= final_step;
		end
	end

	// A partly expanded good frame stays at the queue head until its last result.
	a_step_on_good: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != STEP_STATUS |-> cmd_avail && cmd.kind == CMD_GOOD)
		else $error("sequencer step set without a good frame at the head");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_TERM)
		else $error("sequencer step out of range");

	a_ack_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load && cmd.kind == CMD_GOOD && step_q == STEP_STATUS |=>
		out_valid_q && kind == KIND_STATUS && frame_good && !last)
		else $error("good status not presented ahead of acknowledge bytes");

endmodule

`default_nettype wire

// File: design/length_prefixed_packet_deframer_ack_unit.sv
// Length-prefixed packet deframer with acknowledge, top level.
// A byte that causes results is queued as a command; its results go out through the output register.
// Throughput: one byte per cycle while the FIFO has room; results leave at one per cycle while popped.
// A good terminator's command holds the FIFO head for its five results while bytes queue behind.
// Reset (arst_n low, asynchronous) empties all queues and returns the parser to the length byte.
// Depends on lppd_pkg, lppd_front, lppd_cmd_fifo and lppd_back.
`default_nettype none

module length_prefixed_packet_deframer_ack_unit #(
	parameter int CmdDepth = lppd_pkg::CMD_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire  [7:0] rx_byte,
	output logic       empty,
	input  wire        pop,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic [7:0] byte_index,
	output logic [7:0] frame_opcode,
	output logic [7:0] frame_length,
	output logic       frame_good,
	output logic       last
);
	import lppd_pkg::*;

	// The parser takes a byte whenever the command FIFO has room. Bytes that cause no
	// result (length and opcode) are also held back while the FIFO is full, which keeps
	// the input side simple; the FIFO drains at one result per cycle while results are popped.
	logic fifo_full;
	logic fifo_empty;
	logic take;
	logic enq_valid;
	cmd_t enq_cmd;
	cmd_t head_cmd;
	logic head_done;

	assign full = fifo_full;
	assign take = push && !fifo_full;

	// Front end: parses the frame layout and classifies each byte into a command.
	lppd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.cmd_valid (enq_valid),
		.cmd       (enq_cmd)
	);

	// The command queue decouples the parser from the result sequencer, so bytes can keep
	// arriving while a good terminator's five results go out, until the queue is full.
	lppd_cmd_fifo #(
		.Depth (CmdDepth)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (enq_valid),
		.wr_cmd (enq_cmd),
		.rd_en  (head_done),
		.rd_cmd (head_cmd),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// Back end: turns each command into its results, one per cycle while the output is
	// empty or popped, and holds the oldest result on the output ports until it is popped.
	lppd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (!fifo_empty),
		.cmd          (head_cmd),
		.cmd_done     (head_done),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.byte_value   (byte_value),
		.byte_index   (byte_index),
		.frame_opcode (frame_opcode),
		.frame_length (frame_length),
		.frame_good   (frame_good),
		.last         (last)
	);

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the length-prefixed packet deframer with acknowledge.
// Holds a frame parser scoreboard class and the top module testbench.
// Depends on lppd_pkg and length_prefixed_packet_deframer_ack_unit.
`timescale 1ns / 100ps

module testbench;
	import lppd_pkg::*;

	// Cycles the receiver refuses results while the sender keeps offering bytes.
	localparam int HOLD_CYCLES   = 200;
	// Idle cycles after the last expected result, so that a stray extra result reaching
	// the output register is still caught.
	localparam int SETTLE_CYCLES = 8;
	// Cycles without any accepted transaction before the run is declared hung.
	localparam int STALL_LIMIT   = 5000;
	// Least number of bytes offered after the directed frames, held-off frames included.
	localparam int RANDOM_BYTES  = 500;

	// Parser position within a frame, as the predictor tracks it.
	typedef enum logic [1:0] {
		AWAIT_LENGTH,
		AWAIT_OPCODE,
		IN_PAYLOAD,
		AWAIT_TERM
	} parse_phase_t;

	// One result transaction as it appears on the output ports.
	typedef struct {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic [7:0] frame_opcode;
		logic [7:0] frame_length;
		logic       frame_good;
		logic       last;
	} deframe_result_t;

	// Tracks the frame parser and keeps the results it predicts, oldest first.
	class frame_scoreboard;
		parse_phase_t    phase;
		logic [7:0]      frame_len;
		logic [7:0]      frame_opc;
		logic [7:0]      payload_seen;
		deframe_result_t pending[$];
		int              errors;

		function new();
			phase        = AWAIT_LENGTH;
			frame_len    = 8'd0;
			frame_opc    = 8'd0;
			payload_seen = 8'd0;
			errors       = 0;
		endfunction

		function void queue_result(logic [1:0] k, logic [7:0] v, logic [7:0] idx,
				logic good, logic fin);
			deframe_result_t r;
			r.kind         = k;
			r.byte_value   = v;
			r.byte_index   = idx;
			r.frame_opcode = frame_opc;
			r.frame_length = frame_len;
			r.frame_good   = good;
			r.last         = fin;
			pending.push_back(r);
		endfunction

		// Advances the parser by one accepted byte and queues what it causes.
		function void note_byte(logic [7:0] b);
			case (phase)
				AWAIT_LENGTH: begin
					frame_len    = b;
					payload_seen = 8'd0;
					phase        = AWAIT_OPCODE;
				end
				AWAIT_OPCODE: begin
					frame_opc    = b;
					payload_seen = 8'd0;
					phase        = (frame_len == 8'd0) ? AWAIT_TERM : IN_PAYLOAD;
				end
				IN_PAYLOAD: begin
					queue_result(KIND_PAYLOAD, b, payload_seen, 1'b0, 1'b1);
					payload_seen = payload_seen + 8'd1;
					if (payload_seen >= frame_len)
						phase = AWAIT_TERM;
				end
				default: begin
					if (b == TERM_BYTE) begin
						queue_result(KIND_STATUS, 8'd0, 8'd0, 1'b1, 1'b0);
						queue_result(KIND_ACK, ACK_HEAD, 8'd0, 1'b1, 1'b0);
						queue_result(KIND_ACK, ACK_MARK, 8'd0, 1'b1, 1'b0);
						queue_result(KIND_ACK, frame_opc, 8'd0, 1'b1, 1'b0);
						queue_result(KIND_ACK, TERM_BYTE, 8'd0, 1'b1, 1'b1);
					end else begin
						queue_result(KIND_STATUS, 8'd0, 8'd0, 1'b0, 1'b1);
					end
					phase        = AWAIT_LENGTH;
					payload_seen = 8'd0;
				end
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
				errors++;
			end
		endfunction

		// Compares one accepted result with the oldest prediction.
		function void check_result(deframe_result_t got);
			deframe_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: kind %0d value 0x%02h", got.kind, got.byte_value);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("kind", 8'(want.kind), 8'(got.kind));
			compare_field("byte_value", want.byte_value, got.byte_value);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("frame_opcode", want.frame_opcode, got.frame_opcode);
			compare_field("frame_length", want.frame_length, got.frame_length);
			compare_field("frame_good", 8'(want.frame_good), 8'(got.frame_good));
			compare_field("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [7:0] byte_index;
	logic [7:0] frame_opcode;
	logic [7:0] frame_length;
	logic       frame_good;
	logic       last;

	frame_scoreboard sb;
	bit              hold_req;      // set by the sender to ask for one long receiver hold-off
	int              bytes_sent;
	int              send_calm;     // remaining back-to-back transactions on the input side
	int              recv_calm;     // same for the result side
	int              quiet_cycles = 0;

	// Directed frames. They cover a zero length with a good and with a bad terminator,
	// opcodes and payload bytes at both extremes, a payload byte equal to the terminator
	// value (which must not end the frame), an opcode equal to the terminator value, and
	// bad terminators just beside and far from 0xA5.
	logic [7:0] directed_bytes[$] = '{
		8'h00, 8'h00, 8'hA5,
		8'h00, 8'hFF, 8'h00,
		8'h01, 8'h5A, 8'hFF, 8'hA5,
		8'h02, 8'h81, 8'h00, 8'h7E, 8'hA4,
		8'h03, 8'hC3, 8'h55, 8'hAA, 8'hA5, 8'hFF,
		8'h01, 8'hA5, 8'h01, 8'hA5
	};

	length_prefixed_packet_deframer_ack_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.byte_value  (byte_value),
		.byte_index  (byte_index),
		.frame_opcode(frame_opcode),
		.frame_length(frame_length),
		.frame_good  (frame_good),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length between transactions on one side. Most gaps are zero or short, a few
	// are long, and now and then a calm stretch forces a run of back-to-back transactions.
	function automatic int idle_cycles(ref int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left = $urandom_range(15, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one byte and waits for the block to take it. Outputs are sampled right at
	// the rising edge, so full here is the value the block's flops saw at that edge.
	// With tight set the next byte follows without a gap.
	task automatic send_byte(input logic [7:0] b, input bit tight);
		int gap;
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		gap = tight ? 0 : idle_cycles(send_calm);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A well-formed frame with random opcode and payload. Most terminators are good;
	// the others are random, so an occasional one is good by chance.
	task automatic send_frame(input int len, input bit tight);
		logic [7:0] term;
		send_byte(len[7:0], tight);
		send_byte(8'($urandom_range(0, 255)), tight);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), tight);
		term = ($urandom_range(0, 99) < 80) ? TERM_BYTE : 8'($urandom_range(0, 255));
		send_byte(term, tight);
	endtask

	// Stops offering bytes until every predicted result has been taken, then lets the
	// block settle so that a stray extra result would still be caught.
	task automatic drain();
		if (push)
			push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: reset, the directed frames, then random traffic.
	initial begin
		int len;
		int r;
		sb         = new();
		arst_n     = 1'b0;
		push       = 1'b0;
		rx_byte    = 8'h00;
		hold_req   = 1'b0;
		bytes_sent = 0;
		send_calm  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i], 1'b0);
		drain();

		// The receiver holds off while these frames stream in back to back, so the
		// block has to fill up and push back on its input.
		hold_req = 1'b1;
		send_frame(30, 1'b1);
		send_frame(12, 1'b1);

		while (bytes_sent < directed_bytes.size() + RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// A lone byte breaks the framing; the parser must resume on later bytes.
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					len = $urandom_range(0, 5);
				else if (r < 95)
					len = $urandom_range(6, 24);
				else if (r < 98)
					len = $urandom_range(25, 254);
				else
					len = 255;
				send_frame(len, 1'b0);
			end
			if (bytes_sent >= directed_bytes.size() + RANDOM_BYTES / 2 && !hold_req
					&& send_calm == 0 && $urandom_range(0, 19) == 0)
				drain();
		end
		drain();

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: pop goes high for short bursts, separated by random gaps, except for one
	// long hold-off that the sender asks for.
	initial begin
		int gap;
		pop       = 1'b0;
		recv_calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = idle_cycles(recv_calm);
				if (gap != 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// A result transaction completes at an edge where pop is high and empty is low.
	always @(posedge clk) begin
		deframe_result_t seen;
		if (arst_n && pop && !empty) begin
			seen.kind         = kind;
			seen.byte_value   = byte_value;
			seen.byte_index   = byte_index;
			seen.frame_opcode = frame_opcode;
			seen.frame_length = frame_length;
			seen.frame_good   = frame_good;
			seen.last         = last;
			sb.check_result(seen);
		end
	end

	// Watchdog: the run is hung if no transaction completes on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
